### rtl/jdk_pkg.sv
// Shared types, constants and helpers for the joystick to direction keys block.
`timescale 1ns / 1ps

package jdk_pkg;

	localparam int SAMPLE_BITS = 12;
	localparam int AVG_DEPTH   = 3;
	localparam int CFG_BITS    = 12;
	localparam int CFG_IDX_BITS = 8;
	localparam int KEY_BITS    = 8;
	localparam int NUM_KEYS    = 4;

	localparam int LOG_DEPTH  = $clog2(AVG_DEPTH);
	localparam int SLOT_BITS  = (AVG_DEPTH > 1) ? LOG_DEPTH : 1;
	localparam int SUM_BITS   = SAMPLE_BITS + LOG_DEPTH;
	// floor(sum / AVG_DEPTH) = (sum * DIV_RECIP) >> DIV_SHIFT, exact for any SUM_BITS-wide sum
	localparam int DIV_SHIFT  = SUM_BITS + LOG_DEPTH;
	localparam int RECIP_BITS = DIV_SHIFT + 1;
	localparam int PROD_BITS  = SUM_BITS + RECIP_BITS;
	localparam logic [RECIP_BITS-1:0] DIV_RECIP = RECIP_BITS'(
		((64'd1 << DIV_SHIFT) + 64'(AVG_DEPTH) - 64'd1) / 64'(AVG_DEPTH));

	localparam int OFF_BITS = ((SAMPLE_BITS > CFG_BITS) ? SAMPLE_BITS : CFG_BITS) + 1;
	localparam int MAG_BITS = OFF_BITS - 1;

	// bit positions in the held-key vector
	localparam int KEY_BIT_W = 0;
	localparam int KEY_BIT_A = 1;
	localparam int KEY_BIT_S = 2;
	localparam int KEY_BIT_D = 3;

	localparam logic [KEY_BITS-1:0] KEY_W = 8'h57;
	localparam logic [KEY_BITS-1:0] KEY_A = 8'h41;
	localparam logic [KEY_BITS-1:0] KEY_S = 8'h53;
	localparam logic [KEY_BITS-1:0] KEY_D = 8'h44;

	localparam logic [CFG_BITS-1:0] CENTER_RST  = 12'd2048;
	localparam logic [CFG_BITS-1:0] RELEASE_RST = 12'd15;
	localparam logic [CFG_BITS-1:0] PRESS_RST   = 12'd55;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_REST_X   = 8'd0,
		CFG_REST_Y   = 8'd1,
		CFG_RELEASE  = 8'd2,
		CFG_PRESS    = 8'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] sample_x;
		logic [SAMPLE_BITS-1:0] sample_y;
	} sample_word_t;

	typedef struct packed {
		logic [KEY_BITS-1:0] key_code;
		logic                pressed;
		logic                last;
	} key_event_t;

	typedef struct packed {
		logic en_s1;
		logic en_s2;
		logic en_s3;
	} lane_ctl_t;

	typedef struct packed {
		logic neg_press;
		logic pos_press;
		logic clear;
	} axis_dec_t;

	function automatic logic [KEY_BITS-1:0] key_code_f(input logic [1:0] idx);
		logic [KEY_BITS-1:0] code;
		case (idx)
			2'(KEY_BIT_W): code = KEY_W;
			2'(KEY_BIT_A): code = KEY_A;
			2'(KEY_BIT_S): code = KEY_S;
			2'(KEY_BIT_D): code = KEY_D;
			default:       code = KEY_W;
		endcase
		return code;
	endfunction

endpackage

### rtl/jdk_axis_lane.sv
// One axis lane: sample ring, moving mean, center offset and hysteresis decision.
`timescale 1ns / 1ps

module jdk_axis_lane (
	input  logic                             clk,
	input  logic                             arst_n,
	input  jdk_pkg::lane_ctl_t               ctl,
	input  logic [jdk_pkg::SAMPLE_BITS-1:0]  sample,
	input  logic [jdk_pkg::SLOT_BITS-1:0]    slot,
	input  logic [jdk_pkg::CFG_BITS-1:0]     center,
	input  logic [jdk_pkg::CFG_BITS-1:0]     press_th,
	input  logic [jdk_pkg::CFG_BITS-1:0]     release_th,
	output jdk_pkg::axis_dec_t               dec_s3
);

	logic [jdk_pkg::SAMPLE_BITS-1:0] ring_q [jdk_pkg::AVG_DEPTH];
	logic [jdk_pkg::SUM_BITS-1:0]    sum_c;
	logic [jdk_pkg::SUM_BITS-1:0]    sum_s1;
	logic [jdk_pkg::PROD_BITS-1:0]   prod_c;
	logic [jdk_pkg::SAMPLE_BITS-1:0] mean_s2;
	logic [jdk_pkg::OFF_BITS-1:0]    off_c;
	logic [jdk_pkg::MAG_BITS-1:0]    mag_c;
	logic                            neg_c;
	logic                            press_c;
	logic                            rel_c;

	// sum of the ring as it will be once the new sample lands in its slot
	always_comb begin
		sum_c = '0;
		for (int i = 0; i < jdk_pkg::AVG_DEPTH; i++) begin
			if (jdk_pkg::SLOT_BITS'(i) == slot) begin
				sum_c = sum_c + jdk_pkg::SUM_BITS'(sample);
			end else begin
				sum_c = sum_c + jdk_pkg::SUM_BITS'(ring_q[i]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < jdk_pkg::AVG_DEPTH; i++) begin
				ring_q[i] <= '0;
			end
		end else if (ctl.en_s1) begin
			ring_q[slot] <= sample;
		end
	end

	assign prod_c = jdk_pkg::PROD_BITS'(sum_s1) * jdk_pkg::PROD_BITS'(jdk_pkg::DIV_RECIP);

	assign off_c   = jdk_pkg::OFF_BITS'(mean_s2) - jdk_pkg::OFF_BITS'(center);
	assign neg_c   = off_c[jdk_pkg::OFF_BITS-1];
	assign mag_c   = neg_c ? jdk_pkg::MAG_BITS'(-off_c) : jdk_pkg::MAG_BITS'(off_c);
	assign press_c = mag_c > jdk_pkg::MAG_BITS'(press_th);
	assign rel_c   = mag_c < jdk_pkg::MAG_BITS'(release_th);

	always_ff @(posedge clk) begin
		if (ctl.en_s1) begin
			sum_s1 <= sum_c;
		end
		if (ctl.en_s2) begin
			mean_s2 <= prod_c[jdk_pkg::DIV_SHIFT +: jdk_pkg::SAMPLE_BITS];
		end
		if (ctl.en_s3) begin
			dec_s3.neg_press <= press_c && neg_c;
			dec_s3.pos_press <= press_c && !neg_c;
			dec_s3.clear     <= !press_c && rel_c;
		end
	end

endmodule

### rtl/jdk_event_merge.sv
// Merges both axis decisions into the held keys and emits one key event per word.
`timescale 1ns / 1ps

module jdk_event_merge (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                dec_valid,
	input  jdk_pkg::axis_dec_t  dec_y,
	input  jdk_pkg::axis_dec_t  dec_x,
	output logic                dec_take,
	output logic                keyev_valid,
	input  logic                keyev_ready,
	output jdk_pkg::key_event_t keyev_word
);

	logic [jdk_pkg::NUM_KEYS-1:0] keys_q;
	logic [jdk_pkg::NUM_KEYS-1:0] mask_q;
	logic [jdk_pkg::NUM_KEYS-1:0] want_c;
	logic [jdk_pkg::NUM_KEYS-1:0] rest_c;
	logic [1:0]                   idx_c;
	logic                         free_c;

	always_comb begin
		want_c = keys_q;
		if (dec_y.neg_press) begin
			want_c[jdk_pkg::KEY_BIT_W] = 1'b1;
			want_c[jdk_pkg::KEY_BIT_S] = 1'b0;
		end else if (dec_y.pos_press) begin
			want_c[jdk_pkg::KEY_BIT_S] = 1'b1;
			want_c[jdk_pkg::KEY_BIT_W] = 1'b0;
		end else if (dec_y.clear) begin
			want_c[jdk_pkg::KEY_BIT_W] = 1'b0;
			want_c[jdk_pkg::KEY_BIT_S] = 1'b0;
		end
		if (dec_x.neg_press) begin
			want_c[jdk_pkg::KEY_BIT_A] = 1'b1;
			want_c[jdk_pkg::KEY_BIT_D] = 1'b0;
		end else if (dec_x.pos_press) begin
			want_c[jdk_pkg::KEY_BIT_D] = 1'b1;
			want_c[jdk_pkg::KEY_BIT_A] = 1'b0;
		end else if (dec_x.clear) begin
			want_c[jdk_pkg::KEY_BIT_A] = 1'b0;
			want_c[jdk_pkg::KEY_BIT_D] = 1'b0;
		end
	end

	// lowest pending key goes first: W, A, S, D
	always_comb begin
		if (mask_q[jdk_pkg::KEY_BIT_W]) begin
			idx_c = 2'(jdk_pkg::KEY_BIT_W);
		end else if (mask_q[jdk_pkg::KEY_BIT_A]) begin
			idx_c = 2'(jdk_pkg::KEY_BIT_A);
		end else if (mask_q[jdk_pkg::KEY_BIT_S]) begin
			idx_c = 2'(jdk_pkg::KEY_BIT_S);
		end else begin
			idx_c = 2'(jdk_pkg::KEY_BIT_D);
		end
	end

	assign rest_c      = mask_q & (mask_q - jdk_pkg::NUM_KEYS'(1));
	assign keyev_valid = |mask_q;
	assign free_c      = !keyev_valid || (keyev_ready && rest_c == '0);
	assign dec_take    = dec_valid && free_c;

	assign keyev_word.key_code = jdk_pkg::key_code_f(idx_c);
	assign keyev_word.pressed  = keys_q[idx_c];
	assign keyev_word.last     = rest_c == '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keys_q <= '0;
			mask_q <= '0;
		end else if (dec_take) begin
			keys_q <= want_c;
			mask_q <= want_c ^ keys_q;
		end else if (keyev_valid && keyev_ready) begin
			mask_q <= rest_c;
		end
	end

endmodule

### rtl/joystick_to_direction_keys.sv
// Top level: joystick samples in, W/A/S/D press and release events out.
`timescale 1ns / 1ps

// Joystick to direction keys.
// sample_* channel: one word carries an X and a Y converter reading.
// keyev_* channel: one word per key whose state changed (key code, press or
//   release, last marks the final word for that sample), in the order W, A, S, D.
//   A sample that changes no key gives no word.
// cfg_* channel: register writes (0 center X, 1 center Y, 2 release threshold,
//   3 press threshold); cfg_ready is always high, other indexes are dropped.
//   Write only while no sample is in flight.
// A sample passes the ring sum (registered at acceptance), the reciprocal
//   multiply for the mean, the offset and hysteresis compare, then the event
//   register, each registered in turn; its first event comes from the event
//   register.
// Throughput: one sample per cycle while each gives at most one event and that
//   event is taken at once; more events (up to 4) hold the single event port.
// Reset clears the sample rings, the ring pointer and all held keys, and loads
//   the default registers (center 2048, release 15, press 55).
// Receiver stall: pending events hold, and the three-stage lane pipeline fills
//   before sample_ready drops.
module joystick_to_direction_keys (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   sample_valid,
	output logic                                   sample_ready,
	input  jdk_pkg::sample_word_t                  sample_word,
	output logic                                   keyev_valid,
	input  logic                                   keyev_ready,
	output jdk_pkg::key_event_t                    keyev_word,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [jdk_pkg::CFG_IDX_BITS-1:0]       cfg_index,
	input  logic [jdk_pkg::CFG_BITS-1:0]           cfg_data
);

	logic [jdk_pkg::CFG_BITS-1:0]  rest_x_q;
	logic [jdk_pkg::CFG_BITS-1:0]  rest_y_q;
	logic [jdk_pkg::CFG_BITS-1:0]  release_q;
	logic [jdk_pkg::CFG_BITS-1:0]  press_q;
	logic [jdk_pkg::SLOT_BITS-1:0] slot_q;

	logic v_s1_q;
	logic v_s2_q;
	logic v_s3_q;
	logic free2_c;
	logic free3_c;
	logic in_fire;
	logic merge_take;

	jdk_pkg::lane_ctl_t ctl;
	jdk_pkg::axis_dec_t dec_x;
	jdk_pkg::axis_dec_t dec_y;

	// Register writes, always accepted
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rest_x_q  <= jdk_pkg::CENTER_RST;
			rest_y_q  <= jdk_pkg::CENTER_RST;
			release_q <= jdk_pkg::RELEASE_RST;
			press_q   <= jdk_pkg::PRESS_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				jdk_pkg::CFG_REST_X:  rest_x_q  <= cfg_data;
				jdk_pkg::CFG_REST_Y:  rest_y_q  <= cfg_data;
				jdk_pkg::CFG_RELEASE: release_q <= cfg_data;
				jdk_pkg::CFG_PRESS:   press_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Pipeline flow: a stage loads when the stage ahead is empty or moving
	assign free3_c      = !v_s3_q || merge_take;
	assign free2_c      = !v_s2_q || free3_c;
	assign sample_ready = !v_s1_q || free2_c;
	assign in_fire      = sample_valid && sample_ready;

	assign ctl.en_s1 = in_fire;
	assign ctl.en_s2 = v_s1_q && free2_c;
	assign ctl.en_s3 = v_s2_q && free3_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q <= 1'b0;
			v_s2_q <= 1'b0;
			v_s3_q <= 1'b0;
			slot_q <= '0;
		end else begin
			v_s1_q <= in_fire || (v_s1_q && !free2_c);
			v_s2_q <= ctl.en_s2 || (v_s2_q && !free3_c);
			v_s3_q <= ctl.en_s3 || (v_s3_q && !merge_take);
			if (in_fire) begin
				slot_q <= (slot_q == jdk_pkg::SLOT_BITS'(jdk_pkg::AVG_DEPTH - 1)) ?
					'0 : slot_q + jdk_pkg::SLOT_BITS'(1);
			end
		end
	end

	// Two lanes, one per axis, sharing ring pointer and thresholds
	jdk_axis_lane u_lane_x (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.sample     (sample_word.sample_x),
		.slot       (slot_q),
		.center     (rest_x_q),
		.press_th   (press_q),
		.release_th (release_q),
		.dec_s3     (dec_x)
	);

	jdk_axis_lane u_lane_y (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.sample     (sample_word.sample_y),
		.slot       (slot_q),
		.center     (rest_y_q),
		.press_th   (press_q),
		.release_th (release_q),
		.dec_s3     (dec_y)
	);

	// Merge: apply decisions to held keys, serialize the changes
	jdk_event_merge u_merge (
		.clk         (clk),
		.arst_n      (arst_n),
		.dec_valid   (v_s3_q),
		.dec_y       (dec_y),
		.dec_x       (dec_x),
		.dec_take    (merge_take),
		.keyev_valid (keyev_valid),
		.keyev_ready (keyev_ready),
		.keyev_word  (keyev_word)
	);

	// Input only backs up once every lane stage is occupied
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!sample_ready |-> (v_s1_q && v_s2_q && v_s3_q))
		else $error("sample_ready low with an empty pipeline stage");

	// The last stage waits only on pending events
	a_merge_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3_q && !merge_take) |-> keyev_valid)
		else $error("decision stalled with no event pending");

	// Ring pointer stays within the ring
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		slot_q <= jdk_pkg::SLOT_BITS'(jdk_pkg::AVG_DEPTH - 1))
		else $error("ring pointer out of range");

endmodule
